// ===== rtl/hmis_pkg.sv =====
// ----------------------------------------------------------------------------
// hmis_pkg
// Shared types and constants for the hybrid merge/insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package hmis_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/hmis_cell.sv =====
// ----------------------------------------------------------------------------
// hmis_cell
// One slot of the sorted chain: insert-shift toward the tail, drain-shift
// toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module hmis_cell
  import hmis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire value_t    new_value,
  input  wire logic      prev_gt,
  input  wire logic      prev_valid,
  input  wire value_t    prev_value,
  input  wire logic      next_valid,
  input  wire value_t    next_value,
  output logic           valid,
  output value_t         value,
  output logic           gt
);

  logic   valid_r, valid_nxt;
  value_t value_r, value_nxt;

  // empty slots count as greater than anything
  assign gt = !valid_r || (value_r > new_value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.drain) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (ctl.ins && gt) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        value_nxt = prev_value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;

endmodule

`default_nettype wire

// ===== rtl/hybrid_merge_insertion_sorter_core.sv =====
// ----------------------------------------------------------------------------
// hybrid_merge_insertion_sorter_core
// Stable ascending sorter for sets of signed 32-bit values.
//
// Input channel (in_valid/in_stall): one value per request, in_last closes
// the set. Values are inserted into a chain of MAX_ITEMS cells, one request
// per cycle while loading. Values beyond MAX_ITEMS are dropped and flag the
// set as overflowed.
// After the request with in_last is taken, the input stalls while the chain
// drains through the output register, one result per cycle when out_stall is
// low. The state register switches to drain first, then the first result is
// loaded. out_final_res marks the largest value, out_overflow is set on every
// result of an overflowed set.
// The input reopens as soon as the last result is loaded, even while the
// receiver still stalls it; a stalled result holds.
// Reset empties the chain, clears the count, the overflow flag and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_merge_insertion_sorter_core
  import hmis_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      out_sorted_value,
  output logic                           out_final_res,
  output logic                           out_overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  value_t           out_value_r;
  logic             out_final_r, out_ovf_r;

  logic      in_acc, store, full, out_load;
  cell_ctl_t ctl;

  logic   cell_valid [MAX_ITEMS];
  value_t cell_value [MAX_ITEMS];
  logic   cell_gt    [MAX_ITEMS];

  assign full   = (cnt_r == CNT_W'(MAX_ITEMS));
  assign in_acc = in_valid && !in_stall;
  assign store  = in_acc && !full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load && cnt_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      ST_LOAD:  in_stall = 1'b0;
      ST_DRAIN: out_load = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  assign ctl.ins   = store;
  assign ctl.drain = out_load;

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (in_acc && full) begin
      drop_nxt = 1'b1;
    end
    if (store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (out_load) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        drop_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= cell_value[0];
      out_final_r <= (cnt_r == CNT_W'(1));
      out_ovf_r   <= drop_r;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic   p_gt, p_valid, n_valid;
    value_t p_value, n_value;

    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_mid
      assign p_gt    = cell_gt[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    hmis_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_value  (in_value),
      .prev_gt    (p_gt),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .gt         (cell_gt[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire
